FILE: hdl/lgs_pkg.sv
// Shared types and constants for the diagonal grayscale sampler.
`timescale 1ns / 1ps
package lgs_pkg;

  // Fixed field widths
  localparam int unsigned SizeW    = 6;   // table_size register
  localparam int unsigned CountW   = 7;   // point_count register
  localparam int unsigned IndexW   = 16;  // entry_index
  localparam int unsigned ColorW   = 16;  // one color channel, Q0.16
  localparam int unsigned EntryW   = 3 * ColorW;
  localparam int unsigned CornerW  = ColorW + 2;  // R+G+B sum
  localparam int unsigned PointW   = 6;   // point_index
  localparam int unsigned GrayW    = 16;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 24;

  // Commands carried on tuser
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic {
    REG_TABLE_SIZE  = 1'b0,
    REG_POINT_COUNT = 1'b1
  } reg_e;

  // Extraction sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_POINT,
    ST_PDIV,
    ST_ADDR,
    ST_READ,
    ST_LERP,
    ST_GDIV,
    ST_EMIT
  } state_e;

endpackage

FILE: hdl/lgs_mem.sv
// Color table storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module lgs_mem #(
  parameter int unsigned Depth = 35937,
  parameter int unsigned AddrW = 16
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [lgs_pkg::EntryW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [lgs_pkg::EntryW-1:0] rdata_o
);
  import lgs_pkg::*;

  logic [EntryW-1:0] mem_q [Depth];
  logic [EntryW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data registered while re_i is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lgs_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lgs_div #(
  parameter int unsigned NumW = 61,
  parameter int unsigned DenW = 44
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o,
  output logic [DenW-1:0] rem_o
);
  import lgs_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  // shift in next numerator bit and try subtracting
  assign trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!diff[DenW]) begin
        rem_q <= diff;
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[DenW-1:0];

endmodule

FILE: hdl/lut_diagonal_grayscale_sampler_core.sv
// Top level: table load path, point sequencer, interpolation and output register.
//
//  channel  | direction | tuser / tlast     | tdata
//  s_axis   | in        | command / -       | entry_index, red, green, blue
//  m_axis   | out       | - / last_point    | point_index, gray_level
//  cfg      | in        | write only        | table_size (0), point_count (1)
//
// A write transaction stores one entry; one entry is stored per cycle while no run is active.
// A start transaction runs the sequencer over all n points, dominated by the two serial
// divisions per point on the shared bit-serial divider.
// Reset clears control state only; the color table is undefined until written.
// s_axis_tready is low while a run is active; a stalled m_axis holds the sequencer.
`timescale 1ns / 1ps
module lut_diagonal_grayscale_sampler_core #(
  parameter int unsigned MAX_TABLE_SIZE = 33,
  parameter int unsigned MAX_POINTS     = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_index[15:0], red_value[31:16], green_value[47:32], blue_value[63:48]
  input  logic [lgs_pkg::InDataW-1:0]   s_axis_tdata,
  // command[0]
  input  logic                          s_axis_tuser,
  // stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // point_index[5:0], gray_level[21:6], zero pad [23:22]
  output logic [lgs_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  // configuration
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [lgs_pkg::CountW-1:0]    cfg_data_i
);
  import lgs_pkg::*;

  localparam int unsigned Depth  = MAX_TABLE_SIZE * MAX_TABLE_SIZE * MAX_TABLE_SIZE;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned SW     = $clog2(MAX_TABLE_SIZE + 1);
  localparam int unsigned NW     = $clog2(MAX_POINTS + 1);
  localparam int unsigned IW     = $clog2(MAX_POINTS);
  localparam int unsigned DW     = 2 * NW;
  localparam int unsigned D3W    = 3 * DW;
  localparam int unsigned DenW   = D3W + 2;
  localparam int unsigned TW     = CornerW + D3W;
  localparam int unsigned NumW   = TW + 1;
  localparam int unsigned PW     = 2 * IW + SW;
  localparam int unsigned LW     = CornerW + 2 * DW + 1;  // widest lerp operand

  // configuration registers
  logic [SizeW-1:0]  size_reg_q;
  logic [CountW-1:0] count_reg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_reg_q  <= SizeW'(33);
      count_reg_q <= CountW'(16);
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_TABLE_SIZE:  size_reg_q  <= cfg_data_i[SizeW-1:0];
        REG_POINT_COUNT: count_reg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped run settings
  logic [SW-1:0] s_eff;
  logic [NW-1:0] n_eff;

  always_comb begin
    if (32'(size_reg_q) < 32'd2)                 s_eff = SW'(2);
    else if (32'(size_reg_q) > MAX_TABLE_SIZE)   s_eff = SW'(MAX_TABLE_SIZE);
    else                                         s_eff = SW'(size_reg_q);
    if (32'(count_reg_q) < 32'd2)                n_eff = NW'(2);
    else if (32'(count_reg_q) > MAX_POINTS)      n_eff = NW'(MAX_POINTS);
    else                                         n_eff = NW'(count_reg_q);
  end

  state_e state_q, state_d;
  logic [3:0] step_q;

  logic s_acc;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // table writes
  logic mem_we;
  logic mem_re;
  logic [AddrW-1:0] mem_raddr;
  logic [EntryW-1:0] mem_rdata;

  assign mem_we = s_acc && (cmd_e'(s_axis_tuser) == CMD_WRITE) &&
                  (32'(s_axis_tdata[IndexW-1:0]) < Depth);

  lgs_mem #(.Depth(Depth), .AddrW(AddrW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(s_axis_tdata[IndexW-1:0])),
    .wdata_i (s_axis_tdata[IndexW +: EntryW]),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // run datapath registers
  logic [SW-1:0]    s_q;
  logic [NW-1:0]    nm1_q;
  logic [IW-1:0]    i_q;
  logic [2*SW-1:0]  ss_q;
  logic [DW-1:0]    d_q;
  logic [2*DW-1:0]  d2_q;
  logic [D3W-1:0]   d3_q;
  logic [DenW-1:0]  den_q;
  logic [2*IW-1:0]  ii_q;
  logic [PW-1:0]    p_q;
  logic [SW-1:0]    i0_q, i1_q;
  logic [DW-1:0]    w0_q, w1_q;
  logic [AddrW-1:0] ga0_q, ga1_q, ba0_q, ba1_q;
  logic [CornerW-1:0] v_q [8];
  logic [TW-1:0]    lv_q [7];
  logic [TW-1:0]    acc_q;
  logic [GrayW-1:0] gray_q;

  // divider, shared by index and final divisions
  logic            div_start;
  logic [NumW-1:0] div_num;
  logic [DenW-1:0] div_den;
  logic            div_done;
  logic [NumW-1:0] div_quo;
  logic [DenW-1:0] div_rem;

  lgs_div #(.NumW(NumW), .DenW(DenW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // corner address for the corner being read
  logic [2:0] corner;
  assign corner = step_q[2:0];
  assign mem_raddr = AddrW'(corner[0] ? i1_q : i0_q) + (corner[1] ? ga1_q : ga0_q) +
                     (corner[2] ? ba1_q : ba0_q);

  // lerp operand select
  logic [2:0]    lerp_j;
  logic [LW-1:0] lx, ly;
  assign lerp_j = step_q[3:1];

  always_comb begin
    unique case (lerp_j)
      3'd0: begin lx = LW'(v_q[0]);  ly = LW'(v_q[1]);  end
      3'd1: begin lx = LW'(v_q[4]);  ly = LW'(v_q[5]);  end
      3'd2: begin lx = LW'(v_q[2]);  ly = LW'(v_q[3]);  end
      3'd3: begin lx = LW'(v_q[6]);  ly = LW'(v_q[7]);  end
      3'd4: begin lx = LW'(lv_q[0]); ly = LW'(lv_q[2]); end
      3'd5: begin lx = LW'(lv_q[1]); ly = LW'(lv_q[3]); end
      default: begin lx = LW'(lv_q[4]); ly = LW'(lv_q[5]); end
    endcase
  end

  // output register
  logic out_valid_q;
  logic [IW-1:0] out_idx_q;
  logic [GrayW-1:0] out_gray_q;
  logic out_last_q;
  logic out_load;
  logic last_pt;

  assign last_pt  = (NW'(i_q) == nm1_q);
  assign out_load = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= i_q;
      out_gray_q <= gray_q;
      out_last_q <= last_pt;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_gray_q, PointW'(out_idx_q)};
  assign m_axis_tlast  = out_last_q;

  // sequencer next state and strobes
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = NumW'(p_q);
    div_den   = DenW'(d_q);
    mem_re    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc && cmd_e'(s_axis_tuser) == CMD_START) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        if (step_q == 4'd3) state_d = ST_POINT;
      end
      ST_POINT: begin
        if (step_q == 4'd1) state_d = ST_PDIV;
      end
      ST_PDIV: begin
        if (step_q == 4'd0) div_start = 1'b1;
        if (div_done) state_d = ST_ADDR;
      end
      ST_ADDR: begin
        if (step_q == 4'd3) state_d = ST_READ;
      end
      ST_READ: begin
        mem_re = (step_q < 4'd8);
        if (step_q == 4'd8) state_d = ST_LERP;
      end
      ST_LERP: begin
        if (step_q == 4'd13) state_d = ST_GDIV;
      end
      ST_GDIV: begin
        div_num = NumW'(lv_q[6]) + NumW'(den_q >> 1);
        div_den = den_q;
        if (step_q == 4'd0) div_start = 1'b1;
        if (div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) state_d = last_pt ? ST_IDLE : ST_POINT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) step_q <= '0;
      else if (step_q != 4'hF) step_q <= step_q + 1'b1;
      if (state_q == ST_IDLE) i_q <= '0;
      else if (out_load) i_q <= i_q + 1'b1;
    end
  end

  // run datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        s_q   <= s_eff;
        nm1_q <= n_eff - 1'b1;
      end
      ST_SETUP: begin
        unique case (step_q)
          4'd0: begin
            d_q  <= DW'(nm1_q) * DW'(nm1_q);
            ss_q <= (2*SW)'(s_q) * (2*SW)'(s_q);
          end
          4'd1: d2_q <= (2*DW)'(d_q) * (2*DW)'(d_q);
          4'd2: d3_q <= D3W'(d2_q) * D3W'(d_q);
          default: den_q <= DenW'(d3_q) + DenW'({d3_q, 1'b0});
        endcase
      end
      ST_POINT: begin
        if (step_q == 4'd0) ii_q <= (2*IW)'(i_q) * (2*IW)'(i_q);
        else                p_q  <= PW'(ii_q) * PW'(s_q - 1'b1);
      end
      ST_PDIV: begin
        if (div_done) begin
          i0_q <= SW'(div_quo);
          i1_q <= ((SW+1)'(div_quo[SW-1:0]) + 1'b1 < (SW+1)'(s_q)) ?
                  SW'(div_quo) + 1'b1 : s_q - 1'b1;
          w1_q <= DW'(div_rem);
          w0_q <= d_q - DW'(div_rem);
        end
      end
      ST_ADDR: begin
        unique case (step_q)
          4'd0: ga0_q <= AddrW'(i0_q) * AddrW'(s_q);
          4'd1: ga1_q <= AddrW'(i1_q) * AddrW'(s_q);
          4'd2: ba0_q <= AddrW'(i0_q) * AddrW'(ss_q);
          default: ba1_q <= AddrW'(i1_q) * AddrW'(ss_q);
        endcase
      end
      ST_READ: begin
        if (step_q != 4'd0) begin
          v_q[3'(step_q - 1'b1)] <= CornerW'(mem_rdata[ColorW-1:0]) +
                                    CornerW'(mem_rdata[2*ColorW-1:ColorW]) +
                                    CornerW'(mem_rdata[3*ColorW-1:2*ColorW]);
        end
      end
      ST_LERP: begin
        if (!step_q[0]) acc_q <= TW'(lx) * TW'(w0_q);
        else            lv_q[lerp_j] <= acc_q + TW'(ly) * TW'(w1_q);
      end
      ST_GDIV: begin
        if (div_done) begin
          gray_q <= (div_quo > NumW'(16'hFFFF)) ? 16'hFFFF : div_quo[GrayW-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: tb/lut_diagonal_grayscale_sampler_core_tb.sv
// Testbench for the diagonal grayscale sampler: loads the color table, starts runs, checks points.
`timescale 1ns / 1ps
module lut_diagonal_grayscale_sampler_core_tb;
  import lgs_pkg::*;

  localparam int unsigned TableDepth = 33 * 33 * 33;
  localparam int unsigned CycleLimit = 10000000;

  // One expected grayscale point
  typedef struct packed {
    logic [PointW-1:0] point_index;
    logic [GrayW-1:0]  gray_level;
    logic              last_point;
  } gray_point_t;

  // Keeps a copy of the table and registers, predicts every run's points
  class gray_point_scoreboard;
    logic [EntryW-1:0] color_table [int unsigned];
    logic [SizeW-1:0]  table_size_reg  = 6'd33;
    logic [CountW-1:0] point_count_reg = 7'd16;
    gray_point_t       expected_points [$];
    int unsigned       mismatches = 0;

    function int unsigned eff_size();
      if (table_size_reg < 2) return 2;
      if (table_size_reg > 33) return 33;
      return table_size_reg;
    endfunction

    function int unsigned eff_count();
      if (point_count_reg < 2) return 2;
      if (point_count_reg > 64) return 64;
      return point_count_reg;
    endfunction

    function void write_reg(reg_e idx, logic [CountW-1:0] value);
      if (idx == REG_TABLE_SIZE) table_size_reg = value[SizeW-1:0];
      else point_count_reg = value;
    endfunction

    // Lower diagonal index of point i
    function int unsigned lower_index(int unsigned i, int unsigned n, int unsigned s);
      longint unsigned d, p;
      d = longint'(n - 1) * (n - 1);
      p = longint'(i) * i * (s - 1);
      return int'(p / d);
    endfunction

    function longint unsigned corner_sum(int unsigned r, int unsigned g, int unsigned b,
                                         int unsigned s);
      logic [EntryW-1:0] e;
      e = color_table[r + g * s + b * s * s];
      return longint'(e[15:0]) + e[31:16] + e[47:32];
    endfunction

    function logic [GrayW-1:0] predict_level(int unsigned i, int unsigned n, int unsigned s);
      longint unsigned d, p, rem, w0, w1, den, total, g;
      longint unsigned v000, v100, v010, v001, v110, v101, v011, v111;
      longint unsigned c00, c01, c10, c11, c0, c1;
      int unsigned i0, i1;
      d   = longint'(n - 1) * (n - 1);
      p   = longint'(i) * i * (s - 1);
      i0  = int'(p / d);
      rem = p % d;
      i1  = (i0 + 1 < s) ? i0 + 1 : s - 1;
      w0  = d - rem;
      w1  = rem;
      v000 = corner_sum(i0, i0, i0, s);
      v100 = corner_sum(i1, i0, i0, s);
      v010 = corner_sum(i0, i1, i0, s);
      v001 = corner_sum(i0, i0, i1, s);
      v110 = corner_sum(i1, i1, i0, s);
      v101 = corner_sum(i1, i0, i1, s);
      v011 = corner_sum(i0, i1, i1, s);
      v111 = corner_sum(i1, i1, i1, s);
      c00 = v000 * w0 + v100 * w1;
      c01 = v001 * w0 + v101 * w1;
      c10 = v010 * w0 + v110 * w1;
      c11 = v011 * w0 + v111 * w1;
      c0  = c00 * w0 + c10 * w1;
      c1  = c01 * w0 + c11 * w1;
      total = c0 * w0 + c1 * w1;
      den = 3 * d * d * d;
      g = (total + den / 2) / den;
      if (g > 65535) g = 65535;
      return g[GrayW-1:0];
    endfunction

    // Accepted input transaction: store an entry or queue a whole run
    function void note_input(cmd_e cmd, logic [InDataW-1:0] data);
      int unsigned s, n;
      gray_point_t pt;
      if (cmd == CMD_WRITE) begin
        if (data[15:0] < TableDepth) color_table[data[15:0]] = data[63:16];
      end else begin
        s = eff_size();
        n = eff_count();
        for (int unsigned i = 0; i < n; i++) begin
          pt.point_index = i[PointW-1:0];
          pt.gray_level  = predict_level(i, n, s);
          pt.last_point  = (i == n - 1);
          expected_points.insert(expected_points.size(), pt);
        end
      end
    endfunction

    // Accepted output transaction against the oldest expected point
    function void check_point(logic [OutDataW-1:0] data, logic last);
      gray_point_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected point idx=%0d gray=%0d last=%0b",
                   data[5:0], data[21:6], last);
        return;
      end
      want = expected_points.pop_front();
      if (data[5:0] !== want.point_index || data[21:6] !== want.gray_level ||
          last !== want.last_point) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: point exp idx=%0d gray=%0d last=%0b got idx=%0d gray=%0d last=%0b",
                   want.point_index, want.gray_level, want.last_point,
                   data[5:0], data[21:6], last);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = 1'b0;
  logic [CountW-1:0]   cfg_data_i = '0;

  gray_point_scoreboard sb = new();
  bit          idle_on = 1'b1;
  int unsigned cycles = 0;
  int unsigned item_count = 0;

  lut_diagonal_grayscale_sampler_core u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output stall pattern
  always @(negedge clk_i) begin
    m_axis_tready <= !idle_on || ($urandom_range(99) >= 6);
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_point(m_axis_tdata, m_axis_tlast);
  end

  function automatic logic [ColorW-1:0] pick_color();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return ColorW'($urandom_range(65535));
    endcase
  endfunction

  // One input transaction, with random gaps before it
  task automatic send_item(cmd_e cmd, logic [InDataW-1:0] data);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 6) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = data;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(cmd, data);
    item_count++;
  endtask

  task automatic write_entry(logic [15:0] addr);
    send_item(CMD_WRITE, {pick_color(), pick_color(), pick_color(), addr});
  endtask

  // Writes every diagonal corner the next run reads that is not yet in the table
  task automatic fill_diagonal();
    int unsigned s, n, i0, i1, a;
    s = sb.eff_size();
    n = sb.eff_count();
    for (int unsigned i = 0; i < n; i++) begin
      i0 = sb.lower_index(i, n, s);
      i1 = (i0 + 1 < s) ? i0 + 1 : s - 1;
      for (int unsigned c = 0; c < 8; c++) begin
        a = (c[0] ? i1 : i0) + (c[1] ? i1 : i0) * s + (c[2] ? i1 : i0) * s * s;
        if (!sb.color_table.exists(a)) write_entry(a[15:0]);
      end
    end
  endtask

  task automatic start_run();
    send_item(CMD_START, {$urandom(), $urandom()});
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Waits for the run to drain, then lets the block settle
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(reg_e idx, logic [CountW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic run_phase(logic [CountW-1:0] size_v, logic [CountW-1:0] count_v);
    wait_idle();
    write_cfg(REG_TABLE_SIZE, size_v);
    write_cfg(REG_POINT_COUNT, count_v);
    fill_diagonal();
    start_run();
  endtask

  initial begin
    int unsigned nw, s;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: address and color extremes, ignored writes, range clamps
    send_item(CMD_WRITE, {16'h0000, 16'h0000, 16'h0000, 16'd0});
    send_item(CMD_WRITE, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd35936});
    send_item(CMD_WRITE, {16'h1234, 16'h5678, 16'h9ABC, 16'd35937});
    send_item(CMD_WRITE, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    run_phase(7'd2, 7'd2);
    run_phase(7'd0, 7'd0);
    run_phase(7'd1, 7'd65);
    run_phase(7'd63, 7'd3);
    run_phase(7'd33, 7'd5);
    run_phase(7'd34, 7'd1);

    // Random phases; phase 2 runs with no stalls on either side
    for (int unsigned ph = 0; ph < 3 || item_count < 150; ph++) begin
      wait_idle();
      idle_on = (ph != 2);
      if ($urandom_range(9) == 0) write_cfg(REG_TABLE_SIZE, CountW'($urandom_range(127)));
      else write_cfg(REG_TABLE_SIZE, CountW'($urandom_range(33, 2)));
      if ($urandom_range(9) == 0) write_cfg(REG_POINT_COUNT, CountW'($urandom_range(127)));
      else write_cfg(REG_POINT_COUNT, CountW'($urandom_range(8, 2)));
      s  = sb.eff_size();
      nw = $urandom_range(20, 4);
      for (int unsigned k = 0; k < nw; k++) begin
        if ($urandom_range(4) == 0) write_entry(16'($urandom_range(65535)));
        else write_entry(16'($urandom_range(s * s * s - 1)));
      end
      fill_diagonal();
      start_run();
    end

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
